// File: src/pais_pkg.sv
// ----------------------------------------------------------------------------
// pais_pkg
// Shared types and constants for the positional array block: item formats,
// operation and status codes, and the controller/datapath command interface.
// ----------------------------------------------------------------------------
`default_nettype none

package pais_pkg;

    localparam int DEPTH  = 64;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);

    localparam int FUNC_W = 3;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 7;
    localparam int STAT_W = 3;
    localparam int IDX_W  = 6;
    localparam int CNT_W  = 7;

    typedef enum logic [FUNC_W-1:0] {
        F_CLEAR   = 3'd0,
        F_INSERT  = 3'd1,
        F_DELETE  = 3'd2,
        F_SEARCH  = 3'd3,
        F_DISPLAY = 3'd4
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic signed [VAL_W-1:0] data;
        logic [IDX_W-1:0]        index;
        logic [CNT_W-1:0]        count;
        logic                    last;
    } t_out_item;

    typedef enum logic [2:0] {
        PTR_HOLD  = 3'd0,
        PTR_ZERO  = 3'd1,
        PTR_COUNT = 3'd2,
        PTR_POS   = 3'd3,
        PTR_INC   = 3'd4,
        PTR_DEC   = 3'd5
    } t_ptr_op;

    typedef enum logic [1:0] {
        RS_PTR    = 2'd0,
        RS_PTR_M1 = 2'd1,
        RS_PTR_P1 = 2'd2
    } t_rsel;

    typedef enum logic {
        WS_SHIFT = 1'b0,
        WS_NEW   = 1'b1
    } t_wsel;

    typedef struct packed {
        logic    load_item;
        logic    res_clr;
        logic    res_data_ld;
        logic    res_idx_ld;
        logic    cnt_clr;
        logic    cnt_inc;
        logic    cnt_dec;
        t_ptr_op ptr_op;
        logic    rd_en;
        t_rsel   rd_sel;
        logic    wr_en;
        t_wsel   wr_sel;
        logic    out_ld;
        logic    out_disp;
        t_status status;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  cnt_zero;
        logic  cnt_full;
        logic  pos_gt_cnt;
        logic  pos_ge_cnt;
        logic  ptr_gt_pos;
        logic  ptr_p1_lt_cnt;
        logic  ptr_lt_cnt;
        logic  ptr_last;
        logic  match;
        logic  out_free;
    } t_stat;

endpackage

`default_nettype wire

// File: src/pais_ram.sv
// ----------------------------------------------------------------------------
// pais_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module pais_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: src/pais_dp.sv
// ----------------------------------------------------------------------------
// pais_dp
// Datapath: latched item, fill count, entry pointer, entry memory, result
// staging and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pais_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pais_pkg::t_in_item i_in_data,
    input  wire pais_pkg::t_cmd    i_cmd,
    output pais_pkg::t_stat        o_stat,
    input  wire logic              i_out_stall,
    output logic                   o_out_valid,
    output pais_pkg::t_out_item    o_out_data
);

    pais_pkg::t_func                       r_func;
    logic signed [pais_pkg::VAL_W-1:0]     r_value;
    logic [pais_pkg::POS_W-1:0]            r_pos;
    logic [pais_pkg::CW-1:0]               r_count;
    logic [pais_pkg::CW-1:0]               r_ptr;
    logic [pais_pkg::VAL_W-1:0]            r_res_data;
    logic [pais_pkg::IDX_W-1:0]            r_res_idx;
    logic                                  r_out_valid;
    pais_pkg::t_out_item                   r_out;

    logic [pais_pkg::CW-1:0]               w_ptr_m1;
    logic [pais_pkg::CW:0]                 w_ptr_p1;
    logic [31:0]                           w_pos_x;
    logic [31:0]                           w_cnt_x;
    logic [31:0]                           w_ptr_x;
    logic [31:0]                           w_ptr_p1_x;
    logic                                  w_wr_en;
    logic [pais_pkg::AW-1:0]               w_wr_addr;
    logic [pais_pkg::VAL_W-1:0]            w_wr_data;
    logic [pais_pkg::AW-1:0]               w_rd_addr;
    logic [pais_pkg::VAL_W-1:0]            w_rd_data;
    logic                                  w_out_free;

    assign w_ptr_m1   = r_ptr - pais_pkg::CW'(1);
    assign w_ptr_p1   = {1'b0, r_ptr} + (pais_pkg::CW+1)'(1);
    assign w_pos_x    = 32'(r_pos);
    assign w_cnt_x    = 32'(r_count);
    assign w_ptr_x    = 32'(r_ptr);
    assign w_ptr_p1_x = 32'(w_ptr_p1);
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        w_rd_addr = r_ptr[pais_pkg::AW-1:0];
        case (i_cmd.rd_sel)
            pais_pkg::RS_PTR:    w_rd_addr = r_ptr[pais_pkg::AW-1:0];
            pais_pkg::RS_PTR_M1: w_rd_addr = w_ptr_m1[pais_pkg::AW-1:0];
            pais_pkg::RS_PTR_P1: w_rd_addr = w_ptr_p1[pais_pkg::AW-1:0];
            default:             w_rd_addr = r_ptr[pais_pkg::AW-1:0];
        endcase
    end

    always_comb begin
        w_wr_en   = i_cmd.wr_en;
        w_wr_addr = r_ptr[pais_pkg::AW-1:0];
        w_wr_data = w_rd_data;
        case (i_cmd.wr_sel)
            pais_pkg::WS_SHIFT: begin
                w_wr_addr = r_ptr[pais_pkg::AW-1:0];
                w_wr_data = w_rd_data;
            end
            pais_pkg::WS_NEW: begin
                w_wr_addr = r_pos[pais_pkg::AW-1:0];
                w_wr_data = r_value;
            end
            default: begin
                w_wr_addr = r_ptr[pais_pkg::AW-1:0];
                w_wr_data = w_rd_data;
            end
        endcase
    end

    pais_ram #(
        .WIDTH (pais_pkg::VAL_W),
        .DEPTH (pais_pkg::DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_func  <= pais_pkg::t_func'(i_in_data.func);
            r_value <= i_in_data.value;
            r_pos   <= i_in_data.position;
        end

        case (i_cmd.ptr_op)
            pais_pkg::PTR_HOLD:  r_ptr <= r_ptr;
            pais_pkg::PTR_ZERO:  r_ptr <= '0;
            pais_pkg::PTR_COUNT: r_ptr <= r_count;
            pais_pkg::PTR_POS:   r_ptr <= pais_pkg::CW'(r_pos);
            pais_pkg::PTR_INC:   r_ptr <= w_ptr_p1[pais_pkg::CW-1:0];
            pais_pkg::PTR_DEC:   r_ptr <= w_ptr_m1;
            default:             r_ptr <= r_ptr;
        endcase

        if (i_cmd.res_clr) begin
            r_res_data <= '0;
            r_res_idx  <= '0;
        end else begin
            if (i_cmd.res_data_ld) begin
                r_res_data <= w_rd_data;
            end
            if (i_cmd.res_idx_ld) begin
                r_res_idx <= pais_pkg::IDX_W'(r_ptr);
            end
        end

        if (i_cmd.out_ld) begin
            r_out.status <= i_cmd.status;
            r_out.count  <= pais_pkg::CNT_W'(r_count);
            if (i_cmd.out_disp) begin
                r_out.data  <= w_rd_data;
                r_out.index <= pais_pkg::IDX_W'(r_ptr);
                r_out.last  <= (w_ptr_p1_x == w_cnt_x);
            end else begin
                r_out.data  <= r_res_data;
                r_out.index <= r_res_idx;
                r_out.last  <= 1'b1;
            end
        end

        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_clr) begin
                r_count <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_count <= r_count + pais_pkg::CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - pais_pkg::CW'(1);
            end

            if (i_cmd.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.func          = r_func;
        o_stat.cnt_zero      = (w_cnt_x == 32'd0);
        o_stat.cnt_full      = (w_cnt_x >= 32'(pais_pkg::DEPTH));
        o_stat.pos_gt_cnt    = (w_pos_x > w_cnt_x);
        o_stat.pos_ge_cnt    = (w_pos_x >= w_cnt_x);
        o_stat.ptr_gt_pos    = (w_ptr_x > w_pos_x);
        o_stat.ptr_p1_lt_cnt = (w_ptr_p1_x < w_cnt_x);
        o_stat.ptr_lt_cnt    = (w_ptr_x < w_cnt_x);
        o_stat.ptr_last      = (w_ptr_p1_x == w_cnt_x);
        o_stat.match         = (w_rd_data == r_value);
        o_stat.out_free      = w_out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// File: src/pais_ctrl.sv
// ----------------------------------------------------------------------------
// pais_ctrl
// Controller: sequences each operation over the datapath, at most one memory read
// or write step per cycle, and issues the result loads.
// ----------------------------------------------------------------------------
`default_nettype none

module pais_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire pais_pkg::t_stat i_stat,
    output pais_pkg::t_cmd      o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_DECODE   = 12'b0000_0000_0010,
        S_INS_NXT  = 12'b0000_0000_0100,
        S_INS_WR   = 12'b0000_0000_1000,
        S_DEL_RD   = 12'b0000_0001_0000,
        S_DEL_CAP  = 12'b0000_0010_0000,
        S_DEL_NXT  = 12'b0000_0100_0000,
        S_DEL_WR   = 12'b0000_1000_0000,
        S_SRCH_NXT = 12'b0001_0000_0000,
        S_SRCH_CMP = 12'b0010_0000_0000,
        S_DISP_RD  = 12'b0100_0000_0000,
        S_DISP_OUT = 12'b1000_0000_0000
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic              r_resp;
    logic              n_resp;
    pais_pkg::t_status r_status;
    pais_pkg::t_status n_status;

    always_comb begin
        n_state  = r_state;
        n_resp   = r_resp;
        n_status = r_status;

        o_cmd             = '0;
        o_cmd.ptr_op      = pais_pkg::PTR_HOLD;
        o_cmd.rd_sel      = pais_pkg::RS_PTR;
        o_cmd.wr_sel      = pais_pkg::WS_SHIFT;
        o_cmd.status      = r_status;
        o_in_stall        = 1'b1;

        if (r_resp) begin
            // single-result operations end here, waiting for the output slot
            if (i_stat.out_free) begin
                o_cmd.out_ld = 1'b1;
                n_resp       = 1'b0;
                n_state      = S_IDLE;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    o_in_stall = !i_rst_n;
                    if (i_in_valid && i_rst_n) begin
                        o_cmd.load_item = 1'b1;
                        n_state         = S_DECODE;
                    end
                end
                S_DECODE: begin
                    o_cmd.res_clr = 1'b1;
                    case (i_stat.func)
                        pais_pkg::F_CLEAR: begin
                            o_cmd.cnt_clr = 1'b1;
                            n_status      = pais_pkg::ST_OK;
                            n_resp        = 1'b1;
                        end
                        pais_pkg::F_INSERT: begin
                            if (i_stat.cnt_full) begin
                                n_status = pais_pkg::ST_FULL;
                                n_resp   = 1'b1;
                            end else if (i_stat.pos_gt_cnt) begin
                                n_status = pais_pkg::ST_BADPOS;
                                n_resp   = 1'b1;
                            end else begin
                                o_cmd.ptr_op = pais_pkg::PTR_COUNT;
                                n_state      = S_INS_NXT;
                            end
                        end
                        pais_pkg::F_DELETE: begin
                            if (i_stat.cnt_zero) begin
                                n_status = pais_pkg::ST_EMPTY;
                                n_resp   = 1'b1;
                            end else if (i_stat.pos_ge_cnt) begin
                                n_status = pais_pkg::ST_BADPOS;
                                n_resp   = 1'b1;
                            end else begin
                                o_cmd.ptr_op = pais_pkg::PTR_POS;
                                n_state      = S_DEL_RD;
                            end
                        end
                        pais_pkg::F_SEARCH: begin
                            if (i_stat.cnt_zero) begin
                                n_status = pais_pkg::ST_EMPTY;
                                n_resp   = 1'b1;
                            end else begin
                                o_cmd.ptr_op = pais_pkg::PTR_ZERO;
                                n_state      = S_SRCH_NXT;
                            end
                        end
                        pais_pkg::F_DISPLAY: begin
                            if (i_stat.cnt_zero) begin
                                n_status = pais_pkg::ST_EMPTY;
                                n_resp   = 1'b1;
                            end else begin
                                o_cmd.ptr_op = pais_pkg::PTR_ZERO;
                                n_state      = S_DISP_RD;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
                S_INS_NXT: begin
                    if (i_stat.ptr_gt_pos) begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = pais_pkg::RS_PTR_M1;
                        n_state      = S_INS_WR;
                    end else begin
                        o_cmd.wr_en   = 1'b1;
                        o_cmd.wr_sel  = pais_pkg::WS_NEW;
                        o_cmd.cnt_inc = 1'b1;
                        n_status      = pais_pkg::ST_OK;
                        n_resp        = 1'b1;
                    end
                end
                S_INS_WR: begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = pais_pkg::WS_SHIFT;
                    o_cmd.ptr_op = pais_pkg::PTR_DEC;
                    n_state      = S_INS_NXT;
                end
                S_DEL_RD: begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = pais_pkg::RS_PTR;
                    n_state      = S_DEL_CAP;
                end
                S_DEL_CAP: begin
                    o_cmd.res_data_ld = 1'b1;
                    n_state           = S_DEL_NXT;
                end
                S_DEL_NXT: begin
                    if (i_stat.ptr_p1_lt_cnt) begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = pais_pkg::RS_PTR_P1;
                        n_state      = S_DEL_WR;
                    end else begin
                        o_cmd.cnt_dec = 1'b1;
                        n_status      = pais_pkg::ST_OK;
                        n_resp        = 1'b1;
                    end
                end
                S_DEL_WR: begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = pais_pkg::WS_SHIFT;
                    o_cmd.ptr_op = pais_pkg::PTR_INC;
                    n_state      = S_DEL_NXT;
                end
                S_SRCH_NXT: begin
                    if (i_stat.ptr_lt_cnt) begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = pais_pkg::RS_PTR;
                        n_state      = S_SRCH_CMP;
                    end else begin
                        n_status = pais_pkg::ST_NOTFOUND;
                        n_resp   = 1'b1;
                    end
                end
                S_SRCH_CMP: begin
                    if (i_stat.match) begin
                        o_cmd.res_idx_ld = 1'b1;
                        n_status         = pais_pkg::ST_OK;
                        n_resp           = 1'b1;
                    end else begin
                        o_cmd.ptr_op = pais_pkg::PTR_INC;
                        n_state      = S_SRCH_NXT;
                    end
                end
                S_DISP_RD: begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = pais_pkg::RS_PTR;
                    n_state      = S_DISP_OUT;
                end
                S_DISP_OUT: begin
                    o_cmd.status = pais_pkg::ST_OK;
                    if (i_stat.out_free) begin
                        o_cmd.out_ld   = 1'b1;
                        o_cmd.out_disp = 1'b1;
                        if (i_stat.ptr_last) begin
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.ptr_op = pais_pkg::PTR_INC;
                            n_state      = S_DISP_RD;
                        end
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_resp  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_resp  <= n_resp;
        end
    end

endmodule

`default_nettype wire

// File: src/positional_array_insert_delete_search.sv
// ----------------------------------------------------------------------------
// positional_array_insert_delete_search
// Ordered array of signed entries with insert, delete, search and display.
// Clear and refused operations answer straight from decode; insert shifts the entries
// from the end up to the position, delete shifts the tail down, and search scans from 0.
// Display reads each item through the single registered RAM read before loading it out.
// One item is worked at a time; the next is taken once the last result is loaded.
// Synchronous reset empties the array (fill count 0); the RAM needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_array_insert_delete_search (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire pais_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output pais_pkg::t_out_item      o_out_data
);

    pais_pkg::t_cmd  w_cmd;
    pais_pkg::t_stat w_stat;

    pais_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    pais_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// File: verif/positional_array_insert_delete_search_tb.sv
// ----------------------------------------------------------------------------
// positional_array_insert_delete_search_tb
// Self-checking bench for the positional array block. A short table of
// directed items walks the empty and out-of-range cases. A fill run to full
// follows, with a long output hold-off, then random insert, delete, search and
// display traffic. Every result is checked field by field against the row's
// own value or a shadow copy of the array. Both ports idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_array_insert_delete_search_tb;

    localparam logic [pais_pkg::FUNC_W-1:0] F_UNUSED_LO = 3'd5;
    localparam logic [pais_pkg::FUNC_W-1:0] F_UNUSED_HI = 3'd7;
    localparam int RAND_OPS     = 200;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 300;

    typedef struct {
        pais_pkg::t_in_item  item;
        bit                  typed;
        pais_pkg::t_out_item want;
    } t_row;

    logic                clk;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_stall;
    pais_pkg::t_in_item  in_data     = '0;
    logic                out_valid;
    logic                out_stall   = 1'b0;
    pais_pkg::t_out_item out_data;

    logic signed [pais_pkg::VAL_W-1:0] shadow_entries [pais_pkg::DEPTH];
    int                  shadow_count = 0;
    pais_pkg::t_out_item model_out[$];
    pais_pkg::t_out_item pending_results[$];
    t_row                dir_rows[$];
    pais_pkg::t_out_item got_want;

    int        errors      = 0;
    bit        idle_on     = 1'b1;
    int        hold_ticket = 0;
    int        hold_seen   = 0;
    int        hold_left   = 0;

    positional_array_insert_delete_search i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void array_model(input pais_pkg::t_in_item it);
        pais_pkg::t_out_item r;
        int                  i;
        bit                  hit;
        model_out.delete();
        r      = '0;
        r.last = 1'b1;
        hit    = 1'b0;
        case (it.func)
            pais_pkg::F_CLEAR: begin
                shadow_count = 0;
                r.status     = pais_pkg::ST_OK;
            end
            pais_pkg::F_INSERT: begin
                if (shadow_count >= pais_pkg::DEPTH) begin
                    r.status = pais_pkg::ST_FULL;
                end else if (it.position > shadow_count) begin
                    r.status = pais_pkg::ST_BADPOS;
                end else begin
                    for (i = shadow_count; i > it.position; i--)
                        shadow_entries[i] = shadow_entries[i-1];
                    shadow_entries[it.position] = it.value;
                    shadow_count++;
                    r.status = pais_pkg::ST_OK;
                end
            end
            pais_pkg::F_DELETE: begin
                if (shadow_count == 0) begin
                    r.status = pais_pkg::ST_EMPTY;
                end else if (it.position >= shadow_count) begin
                    r.status = pais_pkg::ST_BADPOS;
                end else begin
                    r.data = shadow_entries[it.position];
                    for (i = it.position; i + 1 < shadow_count; i++)
                        shadow_entries[i] = shadow_entries[i+1];
                    shadow_count--;
                    r.status = pais_pkg::ST_OK;
                end
            end
            pais_pkg::F_SEARCH: begin
                if (shadow_count == 0) begin
                    r.status = pais_pkg::ST_EMPTY;
                end else begin
                    r.status = pais_pkg::ST_NOTFOUND;
                    for (i = 0; i < shadow_count && !hit; i++) begin
                        if (shadow_entries[i] == it.value) begin
                            hit      = 1'b1;
                            r.status = pais_pkg::ST_OK;
                            r.index  = pais_pkg::IDX_W'(i);
                        end
                    end
                end
            end
            pais_pkg::F_DISPLAY: begin
                if (shadow_count == 0) begin
                    r.status = pais_pkg::ST_EMPTY;
                end else begin
                    for (i = 0; i < shadow_count; i++) begin
                        r.status = pais_pkg::ST_OK;
                        r.data   = shadow_entries[i];
                        r.index  = pais_pkg::IDX_W'(i);
                        r.count  = pais_pkg::CNT_W'(shadow_count);
                        r.last   = (i + 1 == shadow_count);
                        model_out.push_back(r);
                    end
                    return;
                end
            end
            default: return;
        endcase
        r.count = pais_pkg::CNT_W'(shadow_count);
        model_out.push_back(r);
    endfunction

    function automatic void add_row(input logic [pais_pkg::FUNC_W-1:0] f,
                                    input logic [pais_pkg::VAL_W-1:0] v,
                                    input logic [pais_pkg::POS_W-1:0] p, input bit typed,
                                    input pais_pkg::t_status st, input int cnt);
        t_row row;
        row.item.func     = f;
        row.item.value    = v;
        row.item.position = p;
        row.typed         = typed;
        row.want          = '0;
        row.want.status   = st;
        row.want.count    = pais_pkg::CNT_W'(cnt);
        row.want.last     = 1'b1;
        dir_rows.push_back(row);
    endfunction

    function automatic pais_pkg::t_in_item rand_item(input bit grow);
        pais_pkg::t_in_item it;
        int                 pick;
        int                 vsel;
        pick = $urandom_range(0, 99);
        vsel = $urandom_range(0, 99);
        if (vsel < 40) begin
            it.value = $signed($urandom_range(0, 6)) - 3;
        end else if (vsel < 50) begin
            case ($urandom_range(0, 3))
                0:       it.value = 32'h8000_0000;
                1:       it.value = 32'h7FFF_FFFF;
                2:       it.value = -1;
                default: it.value = 100;
            endcase
        end else begin
            it.value = $urandom;
        end
        if (pick < (grow ? 60 : 15))
            it.func = pais_pkg::F_INSERT;
        else if (pick < 75)
            it.func = pais_pkg::F_DELETE;
        else if (pick < 88)
            it.func = pais_pkg::F_SEARCH;
        else if (pick < 94)
            it.func = pais_pkg::F_DISPLAY;
        else if (pick < 97)
            it.func = grow ? pais_pkg::F_DISPLAY : pais_pkg::F_CLEAR;
        else
            it.func = pais_pkg::FUNC_W'(F_UNUSED_LO + $urandom_range(0, 2));
        if ($urandom_range(0, 99) < 85)
            it.position = pais_pkg::POS_W'($urandom_range(0,
                              (it.func == pais_pkg::F_DELETE && shadow_count > 0)
                              ? shadow_count - 1 : shadow_count));
        else
            it.position = pais_pkg::POS_W'($urandom_range(0, 127));
        if (it.func == pais_pkg::F_SEARCH && shadow_count > 0 && $urandom_range(0, 99) < 60)
            it.value = shadow_entries[$urandom_range(0, shadow_count - 1)];
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input pais_pkg::t_in_item it, input bit typed,
                             input pais_pkg::t_out_item want);
        while (idle_on && $urandom_range(0, 99) < 12) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        array_model(it);
        if (typed)
            pending_results.push_back(want);
        else
            foreach (model_out[k])
                pending_results.push_back(model_out[k]);
        @(negedge clk);
    endtask

    task automatic field_check(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            errors++;
            $display("%0t: %s expected %0h got %0h", $time, name, exp_v, got_v);
        end
    endtask

    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else if (hold_ticket != hold_seen) begin
            hold_seen = hold_ticket;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end else begin
            out_stall <= idle_on && ($urandom_range(0, 99) < 12);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected item expected none got %p", $time, out_data);
            end else begin
                got_want = pending_results.pop_front();
                field_check("status", got_want.status, out_data.status);
                field_check("data",   got_want.data,   out_data.data);
                field_check("index",  got_want.index,  out_data.index);
                field_check("count",  got_want.count,  out_data.count);
                field_check("last",   got_want.last,   out_data.last);
            end
        end
    end

    initial begin
        pais_pkg::t_in_item it;
        bit                 grow;
        int                 ops_done;
        int                 k;

        add_row(pais_pkg::F_DISPLAY, 0,             0,   1, pais_pkg::ST_EMPTY,    0);
        add_row(pais_pkg::F_DELETE,  0,             127, 1, pais_pkg::ST_EMPTY,    0);
        add_row(pais_pkg::F_DELETE,  0,             0,   1, pais_pkg::ST_EMPTY,    0);
        add_row(pais_pkg::F_SEARCH,  0,             0,   1, pais_pkg::ST_EMPTY,    0);
        add_row(pais_pkg::F_INSERT,  0,             1,   1, pais_pkg::ST_BADPOS,   0);
        add_row(pais_pkg::F_INSERT,  32'h7FFF_FFFF, 0,   1, pais_pkg::ST_OK,       1);
        add_row(pais_pkg::F_INSERT,  32'h8000_0000, 0,   1, pais_pkg::ST_OK,       2);
        add_row(pais_pkg::F_INSERT,  32'hFFFF_FFFF, 2,   1, pais_pkg::ST_OK,       3);
        add_row(pais_pkg::F_INSERT,  100,           1,   1, pais_pkg::ST_OK,       4);
        add_row(pais_pkg::F_INSERT,  100,           4,   1, pais_pkg::ST_OK,       5);
        add_row(pais_pkg::F_SEARCH,  100,           0,   0, pais_pkg::ST_OK,       0);
        add_row(pais_pkg::F_SEARCH,  32'h8000_0000, 0,   0, pais_pkg::ST_OK,       0);
        add_row(pais_pkg::F_SEARCH,  5,             0,   1, pais_pkg::ST_NOTFOUND, 5);
        add_row(pais_pkg::F_DISPLAY, 0,             0,   0, pais_pkg::ST_OK,       0);
        add_row(pais_pkg::F_DELETE,  0,             5,   1, pais_pkg::ST_BADPOS,   5);
        add_row(pais_pkg::F_DELETE,  0,             127, 1, pais_pkg::ST_BADPOS,   5);
        add_row(pais_pkg::F_INSERT,  7,             127, 1, pais_pkg::ST_BADPOS,   5);
        add_row(pais_pkg::F_INSERT,  7,             6,   1, pais_pkg::ST_BADPOS,   5);
        add_row(pais_pkg::F_DELETE,  0,             0,   0, pais_pkg::ST_OK,       0);
        add_row(pais_pkg::F_DELETE,  0,             3,   0, pais_pkg::ST_OK,       0);
        add_row(F_UNUSED_LO,         32'h5A5A_A5A5, 127, 0, pais_pkg::ST_OK,       0);
        add_row(F_UNUSED_HI,         32'hFFFF_FFFF, 0,   0, pais_pkg::ST_OK,       0);
        add_row(pais_pkg::F_CLEAR,   0,             0,   1, pais_pkg::ST_OK,       0);
        add_row(pais_pkg::F_SEARCH,  32'hFFFF_FFFF, 0,   1, pais_pkg::ST_EMPTY,    0);
        add_row(pais_pkg::F_DISPLAY, 0,             0,   1, pais_pkg::ST_EMPTY,    0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[r])
            send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);

        // fill to capacity, then refused inserts on a full array
        for (k = 0; k < pais_pkg::DEPTH; k++) begin
            it          = rand_item(1'b1);
            it.func     = pais_pkg::F_INSERT;
            it.position = pais_pkg::POS_W'($urandom_range(0, shadow_count));
            send_item(it, 1'b0, '0);
        end
        it.func     = pais_pkg::F_INSERT;
        it.position = '0;
        send_item(it, 1'b0, '0);
        it.position = pais_pkg::POS_W'(127);
        send_item(it, 1'b0, '0);

        // long output hold-off while more items queue up behind a full display
        hold_ticket++;
        it.func = pais_pkg::F_DISPLAY;
        send_item(it, 1'b0, '0);
        it.func  = pais_pkg::F_SEARCH;
        it.value = shadow_entries[pais_pkg::DEPTH-1];
        send_item(it, 1'b0, '0);
        it.func     = pais_pkg::F_DELETE;
        it.position = pais_pkg::POS_W'(pais_pkg::DEPTH - 1);
        send_item(it, 1'b0, '0);
        it.position = '0;
        send_item(it, 1'b0, '0);
        for (k = 0; k < 6; k++)
            send_item(rand_item(1'b0), 1'b0, '0);

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);

        grow     = 1'b1;
        ops_done = 0;
        while (ops_done < RAND_OPS) begin
            idle_on = !(ops_done >= 80 && ops_done < 140);
            if (shadow_count >= pais_pkg::DEPTH)
                grow = 1'b0;
            else if (shadow_count < 4)
                grow = 1'b1;
            it = rand_item(grow);
            send_item(it, 1'b0, '0);
            if (it.func <= pais_pkg::F_DISPLAY)
                ops_done++;
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
src/pais_pkg.sv
src/pais_ram.sv
src/pais_dp.sv
src/pais_ctrl.sv
src/positional_array_insert_delete_search.sv
verif/positional_array_insert_delete_search_tb.sv
